@@ src/brf_pkg.sv @@
// Shared types and constants of the byte ring FIFO.
package brf_pkg;

    // Width of the capacity register and of the level and length fields
    localparam int CAP_W = 11;
    // Capacity after reset, before saturation to the store depth
    localparam int CAP_RESET_VAL = 1024;
    // Largest value the capacity register can hold
    localparam int CAP_FIELD_MAX = 2047;

    // Command codes
    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_DISCARD = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // Input transaction
    typedef struct packed {
        cmd_t        command;
        logic [7:0]  write_data;
        logic [15:0] discard_count;
    } req_t;

    // Result transaction
    typedef struct packed {
        logic [7:0]       read_data;
        logic             accepted;
        logic [CAP_W-1:0] fill_level;
        logic             is_empty;
        logic             is_full;
        logic [CAP_W-1:0] first_segment_length;
        logic [CAP_W-1:0] second_segment_length;
    } rsp_t;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_FIN  = 2'b10
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ src/brf_chan_if.sv @@
// Valid/ready channel carrying one payload per transaction.
interface brf_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

@@ src/brf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/brf_ctrl.sv @@
// Controller: sequences one transaction through execute and result load.
module brf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  brf_pkg::dp_status_t status,
    output brf_pkg::dp_cmd_t    cmd
);

    brf_pkg::state_t state_reg;
    brf_pkg::state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        req_ready    = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            brf_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = brf_pkg::ST_FIN;
                end
            end
            brf_pkg::ST_FIN:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = brf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/brf_dp.sv @@
// Datapath: indices, fill level, capacity, byte store and result register.
module brf_dp #(
    parameter int DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  brf_pkg::req_t                  req_data,
    input  logic                           cfg_valid,
    input  logic [brf_pkg::CAP_W-1:0]      cfg_data,
    input  brf_pkg::dp_cmd_t               cmd,
    output brf_pkg::dp_status_t            status,
    output logic                           rsp_valid,
    output brf_pkg::rsp_t                  rsp_data,
    input  logic                           rsp_ready
);

    localparam int CW      = brf_pkg::CAP_W;
    localparam int SW      = CW + 1;
    localparam int AW      = $clog2(DEPTH);
    localparam int CAP_MAX = (DEPTH < brf_pkg::CAP_FIELD_MAX) ? DEPTH
                                                              : brf_pkg::CAP_FIELD_MAX;
    localparam int CAP_RST = (DEPTH < brf_pkg::CAP_RESET_VAL) ? DEPTH
                                                              : brf_pkg::CAP_RESET_VAL;
    localparam int IW      = $clog2(CAP_MAX);

    logic [CW-1:0] cap_reg,  cap_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          acc_reg,  acc_next;
    logic          rd_hit_reg, rd_hit_next;
    logic          out_valid_reg;
    brf_pkg::rsp_t out_reg;

    logic          is_full;
    logic          is_empty;
    logic          wr_ok;
    logic          rd_ok;
    logic          drop_all;
    logic [CW-1:0] head_step;
    logic [SW-1:0] head_sum;
    logic [SW-1:0] head_wrap;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;
    logic [CW-1:0] cap_clamped;
    logic [7:0]    ram_q;
    logic          tail_ahead;
    brf_pkg::rsp_t rsp_new;

    assign is_full  = (fill_reg == cap_reg);
    assign is_empty = (fill_reg == '0);
    assign wr_ok    = (req_data.command == brf_pkg::CMD_WRITE) && !is_full;
    assign rd_ok    = (req_data.command == brf_pkg::CMD_READ) && !is_empty;
    assign drop_all = (req_data.discard_count >= 16'(fill_reg));

    // Head advance: by one on read, by the discard count otherwise
    assign head_step = (req_data.command == brf_pkg::CMD_READ) ? CW'(1)
                                                              : req_data.discard_count[CW-1:0];
    assign head_sum  = SW'(head_reg) + SW'(head_step);
    assign head_wrap = (head_sum >= SW'(cap_reg)) ? head_sum - SW'(cap_reg) : head_sum;
    assign tail_sum  = SW'(tail_reg) + SW'(1);
    assign tail_wrap = (tail_sum >= SW'(cap_reg)) ? tail_sum - SW'(cap_reg) : tail_sum;

    // Capacity write: zero becomes one, large values saturate
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cap_clamped = CW'(1);
        end
        else if (cfg_data > CW'(CAP_MAX))
        begin
            cap_clamped = CW'(CAP_MAX);
        end
        else
        begin
            cap_clamped = cfg_data;
        end
    end

    // State update for one transaction or a capacity write
    always_comb
    begin
        cap_next    = cap_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        acc_next    = acc_reg;
        rd_hit_next = rd_hit_reg;
        if (cfg_valid)
        begin
            cap_next  = cap_clamped;
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end
        else if (cmd.exec)
        begin
            acc_next    = wr_ok || rd_ok;
            rd_hit_next = rd_ok;
            case (req_data.command)
                brf_pkg::CMD_WRITE:
                begin
                    if (wr_ok)
                    begin
                        tail_next = IW'(tail_wrap);
                        fill_next = fill_reg + CW'(1);
                    end
                end
                brf_pkg::CMD_READ:
                begin
                    if (rd_ok)
                    begin
                        head_next = IW'(head_wrap);
                        fill_next = fill_reg - CW'(1);
                    end
                end
                brf_pkg::CMD_DISCARD:
                begin
                    if (!is_empty)
                    begin
                        if (drop_all)
                        begin
                            head_next = '0;
                            tail_next = '0;
                            fill_next = '0;
                        end
                        else
                        begin
                            head_next = IW'(head_wrap);
                            fill_next = fill_reg - head_step;
                        end
                    end
                end
                brf_pkg::CMD_CLEAR:
                begin
                    head_next = '0;
                    tail_next = '0;
                    fill_next = '0;
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CW'(CAP_RST);
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            cap_reg  <= cap_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // Per-transaction flags carried to the result cycle
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        rd_hit_reg <= rd_hit_next;
    end

    // Byte store
    brf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.exec && wr_ok),
        .waddr (AW'(tail_reg)),
        .wdata (req_data.write_data),
        .re    (cmd.exec && rd_ok),
        .raddr (AW'(head_reg)),
        .rdata (ram_q)
    );

    // Result from the updated state
    assign tail_ahead = (tail_reg > head_reg);

    always_comb
    begin
        rsp_new.read_data             = rd_hit_reg ? ram_q : 8'd0;
        rsp_new.accepted              = acc_reg;
        rsp_new.fill_level            = fill_reg;
        rsp_new.is_empty              = is_empty;
        rsp_new.is_full               = is_full;
        rsp_new.first_segment_length  = '0;
        rsp_new.second_segment_length = '0;
        if (!is_empty)
        begin
            if (tail_ahead)
            begin
                rsp_new.first_segment_length = CW'(tail_reg) - CW'(head_reg);
            end
            else
            begin
                rsp_new.first_segment_length  = cap_reg - CW'(head_reg);
                rsp_new.second_segment_length = CW'(tail_reg);
            end
        end
    end

    // Output register
    assign status.out_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= rsp_new;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

@@ src/byte_ring_fifo.sv @@
// Byte ring FIFO with write, read, discard and clear commands.
// Each command runs through the execute and result states of the controller
// around the registered read of the byte store; the result enters the output
// register once it is free, and the next command is taken only after that load.
// Reset: head, tail and fill level clear, capacity becomes min(1024, DEPTH);
// the byte store is not cleared and the block is ready right after reset.
module byte_ring_fifo #(
    parameter int DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    brf_chan_if.sink    req,
    brf_chan_if.source  rsp,
    brf_chan_if.sink    cfg
);

    brf_pkg::dp_cmd_t    dp_cmd;
    brf_pkg::dp_status_t dp_status;
    logic                req_ready;
    logic                rsp_valid;
    brf_pkg::rsp_t       rsp_data;

    // Capacity writes are always taken
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

    brf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    brf_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.data),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .rsp_ready (rsp.ready)
    );

endmodule

@@ tb/brf_tb_pkg.sv @@
// Scoreboard class that tracks the ring FIFO state and checks each status transaction.
`timescale 1ns / 100ps
package brf_tb_pkg;
    import brf_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int SHOW_LIMIT  = 10;

    class ring_tracker;
        logic [7:0]  store [STORE_DEPTH];
        int unsigned head;
        int unsigned tail;
        int unsigned cap;
        bit          full;
        rsp_t        expected_status [$];
        int          mismatch_count;

        function new();
            foreach (store[i])
            begin
                store[i] = '0;
            end
            mismatch_count = 0;
            set_capacity(CAP_W'(CAP_RESET_VAL));
        endfunction

        // Capacity write saturates and empties the ring
        function void set_capacity(logic [CAP_W-1:0] value);
            cap = value;
            if (cap == 0)
            begin
                cap = 1;
            end
            if (cap > STORE_DEPTH)
            begin
                cap = STORE_DEPTH;
            end
            reset_indices();
        endfunction

        function void reset_indices();
            head = 0;
            tail = 0;
            full = 1'b0;
        endfunction

        function int unsigned level();
            if (full)
            begin
                return cap;
            end
            if (tail >= head)
            begin
                return tail - head;
            end
            return cap - head + tail;
        endfunction

        // Index advance with a single wrap at the capacity
        function int unsigned step_index(int unsigned idx, int unsigned by);
            int unsigned n;
            n = idx + by;
            if (n >= cap)
            begin
                n = n - cap;
            end
            return n;
        endfunction

        // Apply one accepted command and queue the status it should produce
        function void note_command(req_t c);
            int unsigned fill;
            rsp_t        r;
            r    = '0;
            fill = level();
            case (c.command)
                CMD_WRITE:
                begin
                    if (!full)
                    begin
                        store[tail] = c.write_data;
                        tail        = step_index(tail, 1);
                        full        = (tail == head);
                        r.accepted  = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (fill != 0)
                    begin
                        r.read_data = store[head];
                        head        = step_index(head, 1);
                        full        = 1'b0;
                        r.accepted  = 1'b1;
                    end
                end
                CMD_DISCARD:
                begin
                    if (c.discard_count != 0 && fill != 0)
                    begin
                        if (c.discard_count >= fill)
                        begin
                            reset_indices();
                        end
                        else
                        begin
                            head = step_index(head, c.discard_count);
                            full = 1'b0;
                        end
                    end
                end
                default:
                begin
                    reset_indices();
                end
            endcase

            // Level, flags and peek segments after the command
            fill         = level();
            r.fill_level = CAP_W'(fill);
            r.is_empty   = (fill == 0);
            r.is_full    = (fill == cap);
            if (fill != 0)
            begin
                if (tail > head)
                begin
                    r.first_segment_length = CAP_W'(tail - head);
                end
                else
                begin
                    r.first_segment_length  = CAP_W'(cap - head);
                    r.second_segment_length = CAP_W'(tail);
                end
            end
            expected_status.push_back(r);
        endfunction

        // Compare one status transaction against the oldest expectation
        function void check_status(rsp_t got);
            rsp_t want;
            if (expected_status.size() == 0)
            begin
                if (mismatch_count < SHOW_LIMIT)
                begin
                    $display("status transaction with none pending: %h", got);
                end
                mismatch_count++;
                return;
            end
            want = expected_status.pop_front();
            if (got.read_data !== want.read_data || got.accepted !== want.accepted ||
                got.fill_level !== want.fill_level || got.is_empty !== want.is_empty ||
                got.is_full !== want.is_full ||
                got.first_segment_length !== want.first_segment_length ||
                got.second_segment_length !== want.second_segment_length)
            begin
                if (mismatch_count < SHOW_LIMIT)
                begin
                    $display("mismatch exp: rd=%h acc=%b lvl=%0d emp=%b full=%b seg=%0d/%0d",
                             want.read_data, want.accepted, want.fill_level, want.is_empty,
                             want.is_full, want.first_segment_length,
                             want.second_segment_length);
                    $display("         got: rd=%h acc=%b lvl=%0d emp=%b full=%b seg=%0d/%0d",
                             got.read_data, got.accepted, got.fill_level, got.is_empty,
                             got.is_full, got.first_segment_length,
                             got.second_segment_length);
                end
                mismatch_count++;
            end
        endfunction

        function int outstanding();
            return expected_status.size();
        endfunction
    endclass

endpackage

@@ tb/tb_top.sv @@
// Top-level testbench: drives commands and capacity writes, checks every status transaction.
`timescale 1ns / 100ps
module tb_top;
    import brf_pkg::*;
    import brf_tb_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int FILL_WRITES  = 1026;

    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic clk;
    logic rst_n;

    brf_chan_if #(.payload_t(req_t)) req ();
    brf_chan_if #(.payload_t(rsp_t)) rsp ();
    brf_chan_if #(.payload_t(logic [CAP_W-1:0])) cfg ();

    byte_ring_fifo #(.DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    ring_tracker tracker = new();
    int          burst_left = 0;
    int          idle_cycles = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Transaction monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                tracker.check_status(rsp.data);
            end
            if (req.valid && req.ready)
            begin
                tracker.note_command(req.data);
            end
            if (cfg.valid && cfg.ready)
            begin
                tracker.set_capacity(cfg.data);
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Status receiver: picks a new stall pattern after each random span
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       period;
        int       on_len;
        int       phase;
        rsp.ready = 1'b0;
        phase     = 0;
        forever
        begin
            mode   = rx_mode_t'($urandom_range(0, 3));
            span   = $urandom_range(50, 250);
            period = $urandom_range(2, 24);
            on_len = $urandom_range(1, period - 1);
            repeat (span)
            begin
                @(negedge clk);
                phase++;
                case (mode)
                    RX_OPEN:     rsp.ready <= 1'b1;
                    RX_LIGHT:    rsp.ready <= ($urandom_range(0, 9) < 7);
                    RX_HEAVY:    rsp.ready <= ($urandom_range(0, 9) < 3);
                    default:     rsp.ready <= ((phase % period) < on_len);
                endcase
            end
        end
    end

    // One command transaction; the sender works in bursts separated by gaps
    task automatic send_cmd(input cmd_t op, input logic [7:0] wd, input logic [15:0] dc);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        req.valid              <= 1'b1;
        req.data.command       <= op;
        req.data.write_data    <= wd;
        req.data.discard_count <= dc;
        do @(posedge clk); while (!req.ready);
    endtask

    // Capacity write once every status has come back
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge clk);
        req.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        burst_left = 0;
    endtask

    // Random commands, alternating between filling and draining trends
    task automatic run_random(input int count);
        bit          filling;
        int          trend_left;
        int unsigned r;
        int unsigned pick;
        int unsigned span_max;
        cmd_t        op;
        logic [15:0] dc;
        filling    = 1'b0;
        trend_left = 0;
        repeat (count)
        begin
            if (trend_left == 0)
            begin
                filling    = !filling;
                span_max   = (2 * tracker.cap + 4 > 150) ? 150 : 2 * tracker.cap + 4;
                trend_left = $urandom_range(4, span_max);
            end
            trend_left--;
            r = $urandom_range(0, 99);
            if (filling)
            begin
                op = (r < 70) ? CMD_WRITE : (r < 88) ? CMD_READ :
                     (r < 97) ? CMD_DISCARD : CMD_CLEAR;
            end
            else
            begin
                op = (r < 25) ? CMD_WRITE : (r < 85) ? CMD_READ :
                     (r < 98) ? CMD_DISCARD : CMD_CLEAR;
            end
            // Discard counts: mostly small, some zero, some full range
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                dc = '0;
            end
            else if (pick < 7)
            begin
                dc = 16'($urandom_range(1, 8));
            end
            else if (pick < 9)
            begin
                dc = 16'($urandom_range(1, 64));
            end
            else
            begin
                dc = 16'($urandom);
            end
            send_cmd(op, 8'($urandom), dc);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.data  = '0;
        cfg.valid = 1'b0;
        cfg.data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset capacity: empty-buffer cases, byte extremes, discard edges
        send_cmd(CMD_READ, 8'h00, 16'd0);
        send_cmd(CMD_DISCARD, 8'h00, 16'd5);
        send_cmd(CMD_DISCARD, 8'hFF, 16'd0);
        send_cmd(CMD_CLEAR, 8'h00, 16'd0);
        send_cmd(CMD_WRITE, 8'h00, 16'hFFFF);
        send_cmd(CMD_WRITE, 8'hFF, 16'd0);
        send_cmd(CMD_WRITE, 8'h5A, 16'd0);
        send_cmd(CMD_WRITE, 8'hA5, 16'd0);
        send_cmd(CMD_READ, 8'hFF, 16'hFFFF);
        send_cmd(CMD_DISCARD, 8'h00, 16'd0);
        send_cmd(CMD_DISCARD, 8'h00, 16'd1);
        send_cmd(CMD_READ, 8'h00, 16'd0);
        send_cmd(CMD_WRITE, 8'h3C, 16'd0);
        send_cmd(CMD_DISCARD, 8'h00, 16'hFFFF);
        send_cmd(CMD_READ, 8'h00, 16'd0);
        run_random(40);

        // Zero capacity acts as one slot: write when full is refused
        write_capacity(11'd0);
        send_cmd(CMD_WRITE, 8'h81, 16'd0);
        send_cmd(CMD_WRITE, 8'h7E, 16'd0);
        send_cmd(CMD_READ, 8'h00, 16'd0);
        send_cmd(CMD_READ, 8'h00, 16'd0);
        send_cmd(CMD_WRITE, 8'h42, 16'd0);
        send_cmd(CMD_DISCARD, 8'h00, 16'd1);
        send_cmd(CMD_WRITE, 8'h24, 16'd0);
        send_cmd(CMD_CLEAR, 8'h00, 16'd0);
        run_random(20);

        // Two slots: tail wraps and the peek splits into two segments
        write_capacity(11'd2);
        send_cmd(CMD_WRITE, 8'h11, 16'd0);
        send_cmd(CMD_READ, 8'h00, 16'd0);
        send_cmd(CMD_WRITE, 8'h22, 16'd0);
        send_cmd(CMD_WRITE, 8'h33, 16'd0);
        send_cmd(CMD_WRITE, 8'h44, 16'd0);
        send_cmd(CMD_READ, 8'h00, 16'd0);
        send_cmd(CMD_READ, 8'h00, 16'd0);
        send_cmd(CMD_READ, 8'h00, 16'd0);
        run_random(30);

        // Register maximum saturates to the store depth; fill it past full
        write_capacity(11'(CAP_FIELD_MAX));
        repeat (FILL_WRITES) send_cmd(CMD_WRITE, 8'($urandom), 16'($urandom));
        repeat (5) send_cmd(CMD_READ, 8'($urandom), 16'd0);
        send_cmd(CMD_DISCARD, 8'h00, 16'd1000);
        run_random(10);

        write_capacity(11'd1024);
        run_random(20);

        write_capacity(11'd1025);
        run_random(10);

        write_capacity(11'd1);
        run_random(20);

        write_capacity(11'd3);
        run_random(20);

        write_capacity(11'd16);
        run_random(20);

        repeat (3)
        begin
            write_capacity(CAP_W'($urandom_range(3, 40)));
            run_random(20);
        end

        write_capacity(CAP_W'($urandom_range(1, CAP_FIELD_MAX)));
        run_random(20);

        // Wait for outstanding status, then a drain period
        @(negedge clk);
        req.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (tracker.mismatch_count == 0 && tracker.outstanding() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/brf_pkg.sv
src/brf_chan_if.sv
src/brf_ram.sv
src/brf_ctrl.sv
src/brf_dp.sv
src/byte_ring_fifo.sv
tb/brf_tb_pkg.sv
tb/tb_top.sv
